/* src/sh24_pkg.sv */
// ----------------------------------------------------------------------------
// sh24_pkg: shared types, constants and functions of the SipHash-2-4 engine
// Holds the initialisation constants, the sequencer states and the SipRound.
// ----------------------------------------------------------------------------
package sh24_pkg;

  localparam logic [63:0] INIT_A    = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_B    = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C    = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_D    = 64'h7465646279746573;
  localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

  // Configuration register indexes.
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam logic [3:0] FULL_BYTES = 4'd8;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sip_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FINAL,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic in_ready;
    logic emit_load;
  } seq_ctrl_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (64 - n));
  endfunction

  function automatic sip_state_t mix_round(input sip_state_t s);
    sip_state_t r;
    r = s;
    r.a = r.a + r.b; r.b = rotl(r.b, 13); r.b = r.b ^ r.a; r.a = rotl(r.a, 32);
    r.c = r.c + r.d; r.d = rotl(r.d, 16); r.d = r.d ^ r.c;
    r.a = r.a + r.d; r.d = rotl(r.d, 21); r.d = r.d ^ r.a;
    r.c = r.c + r.b; r.b = rotl(r.b, 17); r.b = r.b ^ r.c; r.c = rotl(r.c, 32);
    mix_round = r;
  endfunction

  // Keeps the low 'count' bytes of a word; count is already at most eight.
  function automatic logic [63:0] byte_mask(input logic [3:0] count);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < count) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    byte_mask = m;
  endfunction

endpackage

/* src/sh24_if.sv */
// ----------------------------------------------------------------------------
// sh24 stream interfaces: message word channel and tag channel
// Each carries valid, ready and the payload; a transaction completes when both
// valid and ready are high at a rising clock edge.
// ----------------------------------------------------------------------------
interface sh24_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        final_word;

  modport source (output valid, output message_word, output valid_bytes,
                  output final_word, input ready);
  modport sink   (input valid, input message_word, input valid_bytes,
                  input final_word, output ready);
endinterface

interface sh24_tag_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag;

  modport source (output valid, output tag, input ready);
  modport sink   (input valid, input tag, output ready);
endinterface

/* src/siphash_2_4_mac.sv */
// A non-final word is accepted, then absorbed in two SipRounds; a final word then
// runs four finalisation rounds, after two more rounds on a length block if it
// holds 8 bytes. The single shared SipRound unit takes no new word until the last
// is through; the core then waits only while the tag register holds an old tag.
// Reset (synchronous, active high) clears both key registers, closes any open
// message, empties the tag register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// siphash_2_4_mac: keyed SipHash-2-4 engine
// Absorbs 64-bit little-endian message words through one iterated SipRound
// unit and emits the 64-bit tag after the final word of each message.
// ----------------------------------------------------------------------------
module siphash_2_4_mac
  import sh24_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_data,
  sh24_word_if.sink     word_in,
  sh24_tag_if.source    tag_out
);

  // Key registers, sampled only when a message opens.
  logic [63:0] key_low;
  logic [63:0] key_high;

  // The four mixing words and the block currently being absorbed.
  sip_state_t  mix;
  sip_state_t  rnd;
  logic [63:0] block;
  logic [63:0] pad_block;
  logic        pad_pending;
  logic        last_word;
  logic [7:0]  length_mod_256;
  logic        message_open;

  // Round counter: two rounds per absorbed block, four in finalisation.
  logic [1:0]  round_cnt;

  seq_state_t  state;
  seq_state_t  state_next;
  seq_ctrl_t   ctrl;

  logic [63:0] tag;
  logic        tag_valid;

  logic        accept;
  logic [3:0]  count_sat;
  logic        full_last;
  logic [7:0]  length_base;
  logic [7:0]  length_new;
  logic [63:0] first_block;
  sip_state_t  base;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input decode. A non-final word always counts as eight bytes, and a byte
  // count above eight saturates. A final word with eight bytes is absorbed as
  // it stands and the length goes into a separate padding block afterwards;
  // a shorter final word is masked and the length is merged into its top byte.
  // --------------------------------------------------------------------------
  assign accept    = word_in.valid && word_in.ready;
  assign count_sat = (!word_in.final_word || word_in.valid_bytes > FULL_BYTES) ?
                     FULL_BYTES : word_in.valid_bytes;
  assign full_last = word_in.final_word && (count_sat == FULL_BYTES);

  assign length_base = message_open ? length_mod_256 : 8'd0;
  assign length_new  = length_base + {4'd0, count_sat};

  always_comb begin
    if (!word_in.final_word || full_last) begin
      first_block = word_in.message_word;
    end else begin
      first_block = (word_in.message_word & byte_mask(count_sat)) |
                    {length_new, 56'd0};
    end
  end

  // A new message starts from the key mixed into the constants.
  always_comb begin
    if (message_open) begin
      base = mix;
    end else begin
      base.a = INIT_A ^ key_low;
      base.b = INIT_B ^ key_high;
      base.c = INIT_C ^ key_low;
      base.d = INIT_D ^ key_high;
    end
  end

  // The one shared SipRound unit.
  assign rnd = mix_round(mix);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (round_cnt[0]) begin
          if (!last_word) begin
            state_next = ST_IDLE;
          end else if (!pad_pending) begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (round_cnt == 2'd3) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ctrl.emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs. The tag is moved into the output register only once
  // the previous tag has gone or is leaving in this cycle.
  // --------------------------------------------------------------------------
  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE: ctrl.in_ready  = 1'b1;
      ST_EMIT: ctrl.emit_load = !tag_valid || tag_out.ready;
      default: ctrl = '0;
    endcase
  end

  assign word_in.ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      round_cnt    <= '0;
      pad_pending  <= 1'b0;
      message_open <= 1'b0;
      tag_valid    <= 1'b0;
    end else begin
      if (ctrl.emit_load) begin
        tag_valid <= 1'b1;
      end else if (tag_out.ready) begin
        tag_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            round_cnt    <= '0;
            pad_pending  <= full_last;
            message_open <= !word_in.final_word;
          end
        end
        ST_ABSORB: begin
          if (round_cnt[0]) begin
            round_cnt <= '0;
            if (last_word && pad_pending) begin
              pad_pending <= 1'b0;
            end
          end else begin
            round_cnt <= 2'd1;
          end
        end
        ST_FINAL: round_cnt <= round_cnt + 2'd1;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers. The second round of a block also folds the block into
  // the first mixing word and, for a final word, then either opens the length
  // block or starts the finalisation.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mix.a          <= base.a;
          mix.b          <= base.b;
          mix.c          <= base.c;
          mix.d          <= base.d ^ first_block;
          block          <= first_block;
          pad_block      <= {length_new, 56'd0};
          last_word      <= word_in.final_word;
          length_mod_256 <= length_new;
        end
      end
      ST_ABSORB: begin
        if (!round_cnt[0]) begin
          mix <= rnd;
        end else if (!last_word) begin
          mix <= {rnd.a ^ block, rnd.b, rnd.c, rnd.d};
        end else if (pad_pending) begin
          // Eight-byte final word absorbed; start on the length block.
          mix   <= {rnd.a ^ block, rnd.b, rnd.c, rnd.d ^ pad_block};
          block <= pad_block;
        end else begin
          mix <= {rnd.a ^ block, rnd.b, rnd.c ^ FINAL_XOR, rnd.d};
        end
      end
      ST_FINAL: mix <= rnd;
      default: ;
    endcase

    if (ctrl.emit_load) begin
      tag <= mix.a ^ mix.b ^ mix.c ^ mix.d;
    end
  end

  assign tag_out.valid = tag_valid;
  assign tag_out.tag   = tag;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts_absorb: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_ABSORB)
    else $error("accepted word did not start absorption");

  a_final_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && round_cnt == 2'd3) |=> state == ST_EMIT)
    else $error("finalisation did not end after four rounds");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && tag_valid && !tag_out.ready) |=> state == ST_EMIT)
    else $error("tag register overwritten while still held");

  a_open_after_nonfinal: assert property (@(posedge clk) disable iff (rst)
    (accept && !word_in.final_word) |=> message_open)
    else $error("message not kept open after a non-final word");

endmodule

/* test/siphash_tag_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_tag_checker: tag predictor and comparator for the SipHash-2-4 engine
// Follows key writes and accepted word transactions, computes the tag that each
// final word should produce and compares every accepted tag with the oldest one.
// ----------------------------------------------------------------------------
module siphash_tag_checker
  import sh24_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  sh24_word_if        word_mon,
  sh24_tag_if         tag_mon,
  output int          tags_outstanding,
  output int          tag_mismatches
);

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } mix_words_t;

  logic [63:0] key_lo;
  logic [63:0] key_hi;
  mix_words_t  mix;
  logic [7:0]  msg_len;
  logic        msg_open;

  logic [63:0] tags_due[$];
  logic [63:0] predicted;
  logic [63:0] oldest;
  int          errs;

  initial begin
    tags_outstanding = 0;
    tag_mismatches   = 0;
    errs             = 0;
  end

  function automatic logic [63:0] rol64(input logic [63:0] x, input int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic mix_words_t sip_mix(input mix_words_t s);
    s.a = s.a + s.b; s.b = rol64(s.b, 13) ^ s.a; s.a = rol64(s.a, 32);
    s.c = s.c + s.d; s.d = rol64(s.d, 16) ^ s.c;
    s.a = s.a + s.d; s.d = rol64(s.d, 21) ^ s.a;
    s.c = s.c + s.b; s.b = rol64(s.b, 17) ^ s.c; s.c = rol64(s.c, 32);
    return s;
  endfunction

  function automatic mix_words_t absorb_block(input mix_words_t s, input logic [63:0] m);
    s.d = s.d ^ m;
    s = sip_mix(sip_mix(s));
    s.a = s.a ^ m;
    return s;
  endfunction

  // Advances the mixing state by one word; returns 1 when the word closes a
  // message, with the tag that the engine should then emit.
  function automatic bit predict_tag(input logic [63:0] word, input logic [3:0] count,
                                     input logic last, output logic [63:0] tag);
    int          n;
    logic [63:0] block;
    tag = '0;
    if (!msg_open) begin
      mix.a    = INIT_A ^ key_lo;
      mix.b    = INIT_B ^ key_hi;
      mix.c    = INIT_C ^ key_lo;
      mix.d    = INIT_D ^ key_hi;
      msg_len  = '0;
      msg_open = 1'b1;
    end
    if (!last) begin
      mix     = absorb_block(mix, word);
      msg_len = msg_len + 8'd8;
      return 1'b0;
    end
    n = (count > 4'd8) ? 8 : int'(count);
    if (n == 8) begin
      mix     = absorb_block(mix, word);
      msg_len = msg_len + 8'd8;
      block   = '0;
    end else begin
      msg_len = msg_len + 8'(n);
      block   = word & ((64'd1 << (8 * n)) - 64'd1);
    end
    block    = block | {msg_len, 56'd0};
    mix      = absorb_block(mix, block);
    mix.c    = mix.c ^ FINAL_XOR;
    mix      = sip_mix(sip_mix(sip_mix(sip_mix(mix))));
    tag      = mix.a ^ mix.b ^ mix.c ^ mix.d;
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_lo   = '0;
      key_hi   = '0;
      mix      = '0;
      msg_len  = '0;
      msg_open = 1'b0;
      tags_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_KEY_LOW) key_lo = cfg_data;
        else key_hi = cfg_data;
      end
      if (word_mon.valid && word_mon.ready) begin
        if (predict_tag(word_mon.message_word, word_mon.valid_bytes,
                        word_mon.final_word, predicted)) begin
          tags_due.push_back(predicted);
        end
      end
      if (tag_mon.valid && tag_mon.ready) begin
        if (tags_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected tag, expected none, got %h", $time, tag_mon.tag);
        end else begin
          oldest = tags_due.pop_front();
          if (tag_mon.tag !== oldest) begin
            errs++;
            $display("%0t: tag mismatch, expected %h, got %h", $time, oldest, tag_mon.tag);
          end
        end
      end
    end
    tags_outstanding <= tags_due.size();
    tag_mismatches   <= errs;
  end

endmodule

/* test/siphash_2_4_mac_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_2_4_mac_tb: self-checking testbench of the SipHash-2-4 engine
// Drives message words and key writes, applies back-pressure on the tag channel
// and leaves prediction and comparison to the tag checker beside the engine.
// ----------------------------------------------------------------------------
module siphash_2_4_mac_tb;
  import sh24_pkg::*;

  localparam int        HALF_PERIOD  = 6;
  // The slowest word, a final word of eight bytes, also absorbs a length block
  // before it reaches the tag register; a little margin is added on top of that.
  localparam int        DRAIN_CYCLES = 12;
  localparam int        PHASE_WORDS  = 400;
  localparam int        TIMEOUT_NS   = 5_000_000;
  localparam logic [63:0] ALL_ONES   = '1;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [63:0] cfg_data;

  // Percentages of cycles in which the word sender holds back and in which
  // the tag receiver refuses a transaction.
  int sender_idle_pct;
  int stall_pct;
  int words_sent;
  int tags_outstanding;
  int tag_mismatches;

  sh24_word_if word_ch ();
  sh24_tag_if  tag_ch ();

  siphash_2_4_mac uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .word_in   (word_ch),
    .tag_out   (tag_ch)
  );

  siphash_tag_checker tag_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .word_mon         (word_ch),
    .tag_mon          (tag_ch),
    .tags_outstanding (tags_outstanding),
    .tag_mismatches   (tag_mismatches)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // The tag receiver decides afresh at every edge whether it takes a
  // transaction, so stalls land on every phase of the engine's work.
  always @(posedge clk) begin
    tag_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // A hard stop in case the engine hangs or never delivers a tag.
  initial begin
    #TIMEOUT_NS;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Presents one word and returns at the edge where it is accepted. Valid is
  // left high, so that the next word follows without a gap unless the sender
  // decides to idle; it is only lowered where an idle gap begins.
  task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                           input logic last);
    if ($urandom_range(99) < sender_idle_pct) begin
      word_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    word_ch.valid        <= 1'b1;
    word_ch.message_word <= word;
    word_ch.valid_bytes  <= count;
    word_ch.final_word   <= last;
    do @(posedge clk); while (!word_ch.ready);
    words_sent++;
  endtask

  // Stops sending and waits until every tag owed has been taken, then lets
  // the engine run out its latency so that it is truly idle.
  task automatic drain();
    word_ch.valid <= 1'b0;
    do @(posedge clk); while (tags_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the low key register, then the high key register.
  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1);
    cfg_write <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_data  <= k0;
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_data  <= k1;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One message with random content. Most are short; a few are long enough
  // for the byte length to wrap past 255. Now and then a body word claims an
  // odd byte count, which the engine must treat as a full word, and final
  // words sometimes carry counts above eight.
  task automatic send_random_message();
    int         body_words;
    logic [3:0] count;
    if ($urandom_range(99) < 5) body_words = $urandom_range(40, 30);
    else body_words = $urandom_range(4, 0);
    repeat (body_words) begin
      count = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : FULL_BYTES;
      send_word(rand_word(), count, 1'b0);
    end
    count = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    send_word(rand_word(), count, 1'b1);
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [63:0] k0,
                           input logic [63:0] k1);
    int start;
    load_key(k0, k1);
    sender_idle_pct = idle;
    stall_pct       = stall;
    start           = words_sent;
    while (words_sent - start < PHASE_WORDS) send_random_message();
    drain();
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = REG_KEY_LOW;
    cfg_data             = '0;
    word_ch.valid        = 1'b0;
    word_ch.message_word = '0;
    word_ch.valid_bytes  = '0;
    word_ch.final_word   = 1'b0;
    tag_ch.ready         = 1'b0;
    sender_idle_pct      = 0;
    stall_pct            = 0;
    words_sent           = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run at full rate with the all-zero key.
    load_key('0, '0);
    // The empty message: a lone final word that carries no bytes.
    send_word(rand_word(), 4'd0, 1'b1);
    // Full final words at the extremes of the data.
    send_word(ALL_ONES, FULL_BYTES, 1'b1);
    send_word('0, FULL_BYTES, 1'b1);
    // Byte counts above eight saturate to a full word.
    send_word(ALL_ONES, 4'd15, 1'b1);
    send_word(rand_word(), 4'd9, 1'b1);
    // Bytes beyond the count must be masked away, so the unused lanes carry
    // set bits.
    send_word(ALL_ONES, 4'd3, 1'b1);
    send_word(rand_word(), 4'd7, 1'b1);
    send_word(rand_word(), 4'd1, 1'b1);
    // Body words that claim other than eight bytes still count as full.
    send_word(rand_word(), 4'd3, 1'b0);
    send_word(rand_word(), 4'd0, 1'b1);
    send_word(ALL_ONES, 4'd15, 1'b0);
    send_word(rand_word(), 4'd0, 1'b0);
    send_word(rand_word(), 4'd5, 1'b1);
    drain();

    // A key write while a message is open must only affect the next message.
    load_key(ALL_ONES, rand_word());
    send_word(rand_word(), FULL_BYTES, 1'b0);
    drain();
    load_key(rand_word(), rand_word());
    send_word(rand_word(), 4'd4, 1'b1);
    send_word(rand_word(), 4'd6, 1'b1);
    drain();

    // Random part in four phases of back-pressure, each with its own key.
    run_phase(0, 0, ALL_ONES, ALL_ONES);
    run_phase(71, 0, rand_word(), rand_word());
    run_phase(0, 71, '0, ALL_ONES);
    run_phase(23, 23, rand_word(), rand_word());

    if (tag_mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
